// File: src/tcjq_pkg.sv
package tcjq_pkg;

  // Store depths; any value from 4 to 1024 works.
  localparam int HIGH_DEPTH    = 64;
  localparam int REGULAR_DEPTH = 64;

  // Address and count widths follow from the depths.
  localparam int HI_AW = $clog2(HIGH_DEPTH);
  localparam int HI_CW = $clog2(HIGH_DEPTH + 1);
  localparam int RG_AW = $clog2(REGULAR_DEPTH);
  localparam int RG_CW = $clog2(REGULAR_DEPTH + 1);

  localparam int OCC_W    = 8;
  localparam int CNT_MAXW = (HI_CW > RG_CW) ? HI_CW : RG_CW;
  localparam int OCC_SUMW = (CNT_MAXW + 1 > OCC_W) ? CNT_MAXW + 1 : OCC_W;

  localparam logic [1:0] CLASS_D = 2'd3;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_PUT_BACK = 2'd1,
    KIND_REMOVE   = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  job_class;
    logic [15:0] arrival_time;
    logic [15:0] process_time;
    logic [15:0] type_count;
  } in_t;

  typedef struct packed {
    logic        head_valid;
    logic [1:0]  head_class;
    logic [15:0] head_arrival;
    logic [15:0] head_process;
    logic [15:0] head_count;
    logic [7:0]  occupancy;
    logic        dropped;
  } out_t;

  // One stored job, 50 bits.
  typedef struct packed {
    logic [1:0]  job_class;
    logic [15:0] arrival;
    logic [15:0] process;
    logic [15:0] count;
  } job_t;

endpackage

// File: src/two_class_job_queue.sv
// Two-class job queue. High-priority jobs (class D) sit in their own circular
// store and always come out ahead of regular jobs (classes A, B, C), which sit
// in a second circular store; each store is a synchronous single-read RAM.
// An add appends a job to the tail of its class store, a put-back places a
// regular job at the head of the regular store (a class D put-back acts as an
// add), a remove drops the overall head job (no effect when empty) and a clear
// empties both stores. An insertion into a full store is refused and flagged
// in the dropped field. Every transaction on the input produces exactly one
// result transaction carrying the head job after the operation (all zeros
// with head_valid low when empty) and the total occupancy, low 8 bits.
// Timing: a transaction passes through the states S_IDLE, S_READ and S_DONE:
// the accept cycle in S_IDLE applies the write and pointer update, S_READ
// reads the head entry from the RAM, and S_DONE loads the result register.
// The input accepts again as soon as the result register is loaded, so a new
// transaction overlaps a result still waiting on out_ready; the S_DONE state
// of that new transaction repeats for as long as the older result is held.
// No clearing pass is needed after reset: only occupied entries are ever used.
module two_class_job_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcjq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tcjq_pkg::out_t out_data
);
  import tcjq_pkg::*;

  // Control state
  state_t            state_r, state_nxt;
  logic [HI_AW-1:0]  high_head_r, high_head_nxt;
  logic [HI_CW-1:0]  high_count_r, high_count_nxt;
  logic [RG_AW-1:0]  regular_head_r, regular_head_nxt;
  logic [RG_CW-1:0]  regular_count_r, regular_count_nxt;
  logic              dropped_r, dropped_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r;

  // Stores and their registered read ports
  job_t              high_mem [HIGH_DEPTH];
  job_t              regular_mem [REGULAR_DEPTH];
  job_t              high_rdata_r;
  job_t              regular_rdata_r;

  // Datapath signals
  logic              in_fire;
  logic              rd_en;
  logic              out_load;
  logic              high_we;
  logic              regular_we;
  logic [RG_AW-1:0]  regular_waddr;
  job_t              new_job;
  logic              high_full;
  logic              regular_full;
  logic [HI_CW:0]    high_tail_sum;
  logic [RG_CW:0]    regular_tail_sum;
  logic [HI_AW-1:0]  high_tail;
  logic [RG_AW-1:0]  regular_tail;
  logic [RG_AW-1:0]  regular_head_dec;
  logic [HI_AW-1:0]  high_head_inc;
  logic [RG_AW-1:0]  regular_head_inc;
  logic [OCC_SUMW-1:0] occ_sum;
  out_t              result;

  assign in_fire = in_valid && in_ready;

  assign new_job = '{job_class: in_data.job_class,
                     arrival:   in_data.arrival_time,
                     process:   in_data.process_time,
                     count:     in_data.type_count};

  assign high_full    = (high_count_r == HI_CW'(HIGH_DEPTH));
  assign regular_full = (regular_count_r == RG_CW'(REGULAR_DEPTH));

  // Tail = head + count, wrapped once (head < depth, count <= depth).
  assign high_tail_sum    = (HI_CW+1)'(high_head_r) + (HI_CW+1)'(high_count_r);
  assign regular_tail_sum = (RG_CW+1)'(regular_head_r) + (RG_CW+1)'(regular_count_r);
  assign high_tail = (high_tail_sum >= (HI_CW+1)'(HIGH_DEPTH)) ?
                     HI_AW'(high_tail_sum - (HI_CW+1)'(HIGH_DEPTH)) :
                     HI_AW'(high_tail_sum);
  assign regular_tail = (regular_tail_sum >= (RG_CW+1)'(REGULAR_DEPTH)) ?
                        RG_AW'(regular_tail_sum - (RG_CW+1)'(REGULAR_DEPTH)) :
                        RG_AW'(regular_tail_sum);

  // Head steps with wrap at non power-of-two depths too.
  assign regular_head_dec = (regular_head_r == '0) ? RG_AW'(REGULAR_DEPTH - 1) :
                            regular_head_r - RG_AW'(1);
  assign high_head_inc    = (high_head_r == HI_AW'(HIGH_DEPTH - 1)) ? '0 :
                            high_head_r + HI_AW'(1);
  assign regular_head_inc = (regular_head_r == RG_AW'(REGULAR_DEPTH - 1)) ? '0 :
                            regular_head_r + RG_AW'(1);

  // Apply the operation in the accept cycle: store write and pointer update.
  always_comb begin
    high_we           = 1'b0;
    regular_we        = 1'b0;
    regular_waddr     = regular_tail;
    high_head_nxt     = high_head_r;
    high_count_nxt    = high_count_r;
    regular_head_nxt  = regular_head_r;
    regular_count_nxt = regular_count_r;
    dropped_nxt       = dropped_r;
    if (in_fire) begin
      dropped_nxt = 1'b0;
      case (in_data.kind) inside
        KIND_ADD, KIND_PUT_BACK: begin
          if (in_data.job_class == CLASS_D) begin
            // Class D always joins behind the last high job.
            if (high_full) begin
              dropped_nxt = 1'b1;
            end else begin
              high_we        = 1'b1;
              high_count_nxt = high_count_r + HI_CW'(1);
            end
          end else if (regular_full) begin
            dropped_nxt = 1'b1;
          end else begin
            regular_we        = 1'b1;
            regular_count_nxt = regular_count_r + RG_CW'(1);
            if (in_data.kind == KIND_PUT_BACK) begin
              // Put-back: step the head back and store there.
              regular_waddr    = regular_head_dec;
              regular_head_nxt = regular_head_dec;
            end
          end
        end
        KIND_REMOVE: begin
          // Drop the overall head; empty queue stays as is.
          if (high_count_r != '0) begin
            high_head_nxt  = high_head_inc;
            high_count_nxt = high_count_r - HI_CW'(1);
          end else if (regular_count_r != '0) begin
            regular_head_nxt  = regular_head_inc;
            regular_count_nxt = regular_count_r - RG_CW'(1);
          end
        end
        default: begin
          high_head_nxt     = '0;
          high_count_nxt    = '0;
          regular_head_nxt  = '0;
          regular_count_nxt = '0;
        end
      endcase
    end
  end

  // Stores: one write port, one registered read port each. The head read
  // runs in the cycle after the write, so it never collides with it.
  always_ff @(posedge clk) begin
    if (high_we) begin
      high_mem[high_tail] <= new_job;
    end
    if (rd_en) begin
      high_rdata_r <= high_mem[high_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (regular_we) begin
      regular_mem[regular_waddr] <= new_job;
    end
    if (rd_en) begin
      regular_rdata_r <= regular_mem[regular_head_r];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Assemble the result from the updated counts and the head read data.
  assign occ_sum = OCC_SUMW'(high_count_r) + OCC_SUMW'(regular_count_r);

  always_comb begin
    result            = '0;
    result.occupancy  = occ_sum[OCC_W-1:0];
    result.dropped    = dropped_r;
    if (high_count_r != '0) begin
      result.head_valid   = 1'b1;
      result.head_class   = high_rdata_r.job_class;
      result.head_arrival = high_rdata_r.arrival;
      result.head_process = high_rdata_r.process;
      result.head_count   = high_rdata_r.count;
    end else if (regular_count_r != '0) begin
      result.head_valid   = 1'b1;
      result.head_class   = regular_rdata_r.job_class;
      result.head_arrival = regular_rdata_r.arrival;
      result.head_process = regular_rdata_r.process;
      result.head_count   = regular_rdata_r.count;
    end
  end

  // Result register: hold until taken, load when free or being drained.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      high_head_r     <= '0;
      high_count_r    <= '0;
      regular_head_r  <= '0;
      regular_count_r <= '0;
      dropped_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      high_head_r     <= high_head_nxt;
      high_count_r    <= high_count_nxt;
      regular_head_r  <= regular_head_nxt;
      regular_count_r <= regular_count_nxt;
      dropped_r       <= dropped_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
